FILE: design/stsk_pkg.sv
// ----------------------------------------------------------------------------
// stsk_pkg
// Shared types and constants for the strongest-sighting selection table.
// ----------------------------------------------------------------------------
package stsk_pkg;

   localparam int TABLE_DEPTH_DEFAULT  = 128;
   localparam int MAX_SELECTED_DEFAULT = 16;

   localparam logic OP_INGEST = 1'b0;
   localparam logic OP_BUILD  = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [47:0]       device_address;
      logic [7:0]        device_kind;
      logic signed [7:0] signal_dbm;
   } req_type;

   typedef struct packed {
      logic [47:0]       out_address;
      logic [7:0]        out_kind;
      logic signed [7:0] out_signal_dbm;
      logic [5:0]        rank;
      logic [6:0]        selected_count;
      logic              last;
   } rsp_type;

   // one stored sighting
   typedef struct packed {
      logic [47:0]       address;
      logic [7:0]        kind;
      logic signed [7:0] sig_dbm;
   } entry_type;

endpackage

FILE: design/stsk_entry_ram.sv
// ----------------------------------------------------------------------------
// stsk_entry_ram
// Sighting table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stsk_entry_ram #(
   parameter int DEPTH = stsk_pkg::TABLE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  stsk_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output stsk_pkg::entry_type rd_data
);

   stsk_pkg::entry_type mem [DEPTH];
   stsk_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scan_table_strongest_k_select.sv
// ----------------------------------------------------------------------------
// scan_table_strongest_k_select
// Table of radio sightings with merge-on-match ingest and a strongest-first
// selection build that empties the table.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start & !busy
//  response  rsp_strobe, rsp_data           one-cycle strobe per result, no stall
//
// ingest: one table read per cycle via the single read port of the entry memory;
//   a match ends the walk, else the last entry does and appends unless full.
// build: for each of k outputs one pass over entries rank..count-1, its result
//   strobed in the cycle after the pass. reset clears the state, the entry
//   count, the read-valid and the strobe flag; the memory keeps stale contents
//   that are never read. busy drops in the cycle that strobes the last result.
// ----------------------------------------------------------------------------
module scan_table_strongest_k_select #(
   parameter int TABLE_DEPTH  = stsk_pkg::TABLE_DEPTH_DEFAULT,
   parameter int MAX_SELECTED = stsk_pkg::MAX_SELECTED_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  stsk_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output stsk_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MATCH  = 2'd1;
   localparam logic [1:0] ST_SELECT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       k_ff, k_in;
   stsk_pkg::req_type   req_ff, req_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   stsk_pkg::entry_type best_ff, best_in;
   logic [CW-1:0]       best_idx_ff, best_idx_in;
   stsk_pkg::entry_type first_ff, first_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   stsk_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                issue;
   logic                last_rd;
   logic                hit;
   logic                take;
   logic [CW-1:0]       pos_next;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   stsk_pkg::entry_type wr_data;
   stsk_pkg::entry_type rd_q;
   stsk_pkg::entry_type first_now;
   stsk_pkg::entry_type best_now;
   logic [CW-1:0]       best_idx_now;
   stsk_pkg::entry_type new_entry;

   stsk_entry_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[IW-1:0]),
      .rd_data (rd_q)
   );

   always_comb begin
      issue    = (state_ff != ST_IDLE) && (ptr_ff < count_ff);
      last_rd  = rd_valid_ff && (rd_idx_ff == count_ff - 1'b1);
      hit      = rd_valid_ff && (rd_q.kind == req_ff.device_kind)
                 && (rd_q.address == req_ff.device_address);
      pos_next = pos_ff + 1'b1;

      new_entry.address = req_ff.device_address;
      new_entry.kind    = req_ff.device_kind;
      new_entry.sig_dbm = req_ff.signal_dbm;

      // running maximum, first one found wins on ties
      first_now    = (rd_idx_ff == pos_ff) ? rd_q : first_ff;
      take         = (rd_idx_ff == pos_ff) || ($signed(rd_q.sig_dbm) > $signed(best_ff.sig_dbm));
      best_now     = take ? rd_q : best_ff;
      best_idx_now = take ? rd_idx_ff : best_idx_ff;

      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = issue ? ptr_ff + 1'b1 : ptr_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      req_in        = req_ff;
      rd_valid_in   = issue;
      rd_idx_in     = ptr_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      first_in      = first_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = new_entry;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.opcode == stsk_pkg::OP_BUILD) begin
                  if (count_ff != '0) begin
                     if (int'(count_ff) < MAX_SELECTED) begin
                        k_in = count_ff;
                     end else begin
                        k_in = CW'(MAX_SELECTED);
                     end
                     pos_in   = '0;
                     ptr_in   = '0;
                     state_in = ST_SELECT;
                  end
               end else if (count_ff == '0) begin
                  // empty table: append straight away
                  wr_en           = 1'b1;
                  wr_addr         = '0;
                  wr_data.address = req_data.device_address;
                  wr_data.kind    = req_data.device_kind;
                  wr_data.sig_dbm = req_data.signal_dbm;
                  count_in        = CW'(1);
               end else begin
                  ptr_in   = '0;
                  state_in = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            if (hit) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff[IW-1:0];
               wr_data = rd_q;
               if ($signed(req_ff.signal_dbm) > $signed(rd_q.sig_dbm)) begin
                  wr_data.sig_dbm = req_ff.signal_dbm;
               end
               state_in = ST_IDLE;
            end else if (last_rd) begin
               if (count_ff < DEPTH_C) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IW-1:0];
                  wr_data  = new_entry;
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SELECT: begin
            if (rd_valid_ff) begin
               first_in    = first_now;
               best_in     = best_now;
               best_idx_in = best_idx_now;
               if (last_rd) begin
                  // swap: old occupant of this rank moves to the winner's slot
                  wr_en   = 1'b1;
                  wr_addr = best_idx_now[IW-1:0];
                  wr_data = first_now;
                  rsp_strobe_in              = 1'b1;
                  rsp_data_in.out_address    = best_now.address;
                  rsp_data_in.out_kind       = best_now.kind;
                  rsp_data_in.out_signal_dbm = best_now.sig_dbm;
                  rsp_data_in.rank           = 6'(pos_ff);
                  rsp_data_in.selected_count = 7'(k_ff);
                  rsp_data_in.last           = (pos_next == k_ff);
                  pos_in = pos_next;
                  ptr_in = pos_next;
                  if (pos_next == k_ff) begin
                     count_in = '0;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ptr_ff      <= ptr_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: tb/tb_scan_table_strongest_k_select.sv
// ----------------------------------------------------------------------------
// tb_scan_table_strongest_k_select
// Self-checking bench for the sighting table: a short table of directed
// requests, then bursts of sightings from small address pools closed by a
// build, and one pass that fills the table past its depth. Every result is
// compared field by field with the table model or a fixed expected value.
// ----------------------------------------------------------------------------
module tb_scan_table_strongest_k_select;

   localparam int PERIOD      = 12;
   localparam int DEPTH       = stsk_pkg::TABLE_DEPTH_DEFAULT;
   localparam int PICK_LIMIT  = stsk_pkg::MAX_SELECTED_DEFAULT;
   localparam int ADDR_POOL   = 20;
   localparam int KIND_POOL   = 4;
   localparam int RUN_CYCLES  = 800_000;

   typedef enum int {CHK_MODEL, CHK_NONE, CHK_ONE} check_type;

   typedef struct {
      stsk_pkg::req_type req;
      check_type         chk;
      stsk_pkg::rsp_type want;
   } stim_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              start      = 1'b0;
   stsk_pkg::req_type req_data   = '0;
   logic              busy;
   logic              rsp_strobe;
   stsk_pkg::rsp_type rsp_data;

   // behavioural copy of the table
   stsk_pkg::entry_type sightings [DEPTH];
   int                  sighting_count = 0;
   stsk_pkg::rsp_type   pending_picks [$];

   logic [47:0]  addr_pool [ADDR_POOL];
   logic [7:0]   kind_pool [KIND_POOL];
   stim_row_type stim_table [$];
   int           n_errors = 0;

   scan_table_strongest_k_select i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #(PERIOD / 2) clock = 1'b1;
      #(PERIOD / 2) clock = 1'b0;
   end

   function automatic void record_sighting(stsk_pkg::req_type req);
      for (int i = 0; i < sighting_count; i++) begin
         if (sightings[i].kind == req.device_kind
             && sightings[i].address == req.device_address) begin
            if (req.signal_dbm > sightings[i].sig_dbm)
               sightings[i].sig_dbm = req.signal_dbm;
            return;
         end
      end
      // full table drops a new sighting
      if (sighting_count < DEPTH) begin
         sightings[sighting_count] = '{req.device_address, req.device_kind, req.signal_dbm};
         sighting_count++;
      end
   endfunction

   function automatic void rank_strongest(bit keep);
      int                  n;
      int                  k;
      int                  best;
      stsk_pkg::entry_type swap_tmp;
      stsk_pkg::rsp_type   pick;
      n = sighting_count;
      k = (n < PICK_LIMIT) ? n : PICK_LIMIT;
      // first maximum from position i onward is swapped in, so ties follow the swaps
      for (int i = 0; i < k; i++) begin
         best = i;
         for (int j = i + 1; j < n; j++)
            if (sightings[j].sig_dbm > sightings[best].sig_dbm)
               best = j;
         if (best != i) begin
            swap_tmp        = sightings[i];
            sightings[i]    = sightings[best];
            sightings[best] = swap_tmp;
         end
      end
      for (int i = 0; i < k; i++) begin
         pick.out_address    = sightings[i].address;
         pick.out_kind       = sightings[i].kind;
         pick.out_signal_dbm = sightings[i].sig_dbm;
         pick.rank           = 6'(i);
         pick.selected_count = 7'(k);
         pick.last           = (i == k - 1);
         if (keep)
            pending_picks.push_back(pick);
      end
      sighting_count = 0;
   endfunction

   function automatic void predict_request(stsk_pkg::req_type req, bit keep);
      if (req.opcode == stsk_pkg::OP_INGEST)
         record_sighting(req);
      else
         rank_strongest(keep);
   endfunction

   function automatic void add_row(logic op, logic [47:0] addr, logic [7:0] kind,
                                   logic [7:0] dbm, check_type chk,
                                   stsk_pkg::rsp_type want = '0);
      stim_row_type row;
      row.req  = '{op, addr, kind, dbm};
      row.chk  = chk;
      row.want = want;
      stim_table.push_back(row);
   endfunction

   function automatic void refresh_pools();
      foreach (addr_pool[i])
         addr_pool[i] = {16'($urandom), 32'($urandom)};
      foreach (kind_pool[i])
         kind_pool[i] = 8'($urandom);
   endfunction

   function automatic stsk_pkg::req_type random_sighting();
      stsk_pkg::req_type r;
      r.opcode         = stsk_pkg::OP_INGEST;
      r.device_address = ($urandom_range(9) < 7) ? addr_pool[$urandom_range(ADDR_POOL - 1)]
                                                 : {16'($urandom), 32'($urandom)};
      r.device_kind    = ($urandom_range(9) < 7) ? kind_pool[$urandom_range(KIND_POOL - 1)]
                                                 : 8'($urandom);
      // narrow band of strengths makes ties common
      r.signal_dbm     = $urandom_range(1) ? 8'(-40 - $urandom_range(2)) : 8'($urandom);
      return r;
   endfunction

   function automatic stsk_pkg::req_type random_build();
      stsk_pkg::req_type r;
      r                = {1'b0, 16'($urandom), 32'($urandom), 16'($urandom)};
      r.opcode         = stsk_pkg::OP_BUILD;
      return r;
   endfunction

   task automatic issue_request(stsk_pkg::req_type req, int idle_pct);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic send_request(stsk_pkg::req_type req, int idle_pct);
      issue_request(req, idle_pct);
      predict_request(req, 1'b1);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_picks.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_bursts(int budget, int idle_pct);
      int                sent;
      int                len;
      stsk_pkg::req_type r;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(3) == 0)
            refresh_pools();
         len = $urandom_range(0, 24);
         for (int i = 0; i < len; i++) begin
            // occasional random request; an ingest draw becomes a normal sighting
            if ($urandom_range(9) == 0) begin
               r = {16'($urandom), 32'($urandom), 17'($urandom)};
               if (r.opcode == stsk_pkg::OP_INGEST)
                  r = random_sighting();
            end else begin
               r = random_sighting();
            end
            send_request(r, idle_pct);
         end
         send_request(random_build(), idle_pct);
         sent += len + 1;
      end
   endtask

   task automatic fill_table(int idle_pct);
      stsk_pkg::req_type r;
      stsk_pkg::req_type kept;
      for (int i = 0; i < DEPTH; i++) begin
         r = random_sighting();
         r.device_address = {16'(i), 32'($urandom)};
         if (i == 5)
            kept = r;
         send_request(r, idle_pct);
      end
      // a match still merges when full, new sightings are dropped
      kept.signal_dbm = 8'h7f;
      send_request(kept, idle_pct);
      r = random_sighting();
      r.device_address = 48'hFFFF_0000_0001;
      r.signal_dbm     = 8'h7f;
      send_request(r, idle_pct);
      r.device_address = 48'hFFFF_0000_0002;
      send_request(r, idle_pct);
      send_request(random_build(), idle_pct);
   endtask

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      stsk_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_picks.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
         end else begin
            want = pending_picks.pop_front();
            compare_field("out_address", want.out_address, rsp_data.out_address);
            compare_field("out_kind", want.out_kind, rsp_data.out_kind);
            compare_field("out_signal_dbm", want.out_signal_dbm, rsp_data.out_signal_dbm);
            compare_field("rank", want.rank, rsp_data.rank);
            compare_field("selected_count", want.selected_count, rsp_data.selected_count);
            compare_field("last", want.last, rsp_data.last);
         end
      end
   end

   initial begin
      #(PERIOD * RUN_CYCLES);
      $display("FAIL");
      $finish;
   end

   initial begin
      // empty table, extremes, merge, kind split, ties
      add_row(stsk_pkg::OP_BUILD,  48'h0,              8'h00, 8'h00, CHK_NONE);
      add_row(stsk_pkg::OP_BUILD,  48'hFFFF_FFFF_FFFF, 8'hFF, 8'h7f, CHK_NONE);
      add_row(stsk_pkg::OP_INGEST, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'h7f, CHK_MODEL);
      add_row(stsk_pkg::OP_BUILD,  48'h0,              8'h00, 8'h80, CHK_ONE,
              '{48'hFFFF_FFFF_FFFF, 8'hFF, 8'h7f, 6'd0, 7'd1, 1'b1});
      add_row(stsk_pkg::OP_INGEST, 48'h0,              8'h00, 8'h80, CHK_MODEL);
      add_row(stsk_pkg::OP_BUILD,  48'hFFFF_FFFF_FFFF, 8'hFF, 8'h7f, CHK_ONE,
              '{48'h0, 8'h00, 8'h80, 6'd0, 7'd1, 1'b1});
      add_row(stsk_pkg::OP_INGEST, 48'hAAAA_AAAA_AAAA, 8'h55, 8'hce, CHK_MODEL);
      add_row(stsk_pkg::OP_INGEST, 48'hAAAA_AAAA_AAAA, 8'h55, 8'hec, CHK_MODEL);
      add_row(stsk_pkg::OP_INGEST, 48'hAAAA_AAAA_AAAA, 8'h55, 8'ha6, CHK_MODEL);
      add_row(stsk_pkg::OP_INGEST, 48'hAAAA_AAAA_AAAA, 8'hAA, 8'hec, CHK_MODEL);
      add_row(stsk_pkg::OP_INGEST, 48'h5555_5555_5555, 8'h55, 8'hec, CHK_MODEL);
      add_row(stsk_pkg::OP_INGEST, 48'h0000_0000_0001, 8'h01, 8'h00, CHK_MODEL);
      add_row(stsk_pkg::OP_INGEST, 48'h8000_0000_0000, 8'h80, 8'h80, CHK_MODEL);
      add_row(stsk_pkg::OP_INGEST, 48'h7FFF_FFFF_FFFF, 8'h7F, 8'h7f, CHK_MODEL);
      add_row(stsk_pkg::OP_BUILD,  48'h1234_5678_9ABC, 8'h3C, 8'h81, CHK_MODEL);

      refresh_pools();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         issue_request(stim_table[i].req, 31);
         predict_request(stim_table[i].req, stim_table[i].chk == CHK_MODEL);
         if (stim_table[i].chk == CHK_ONE)
            pending_picks.push_back(stim_table[i].want);
      end
      drain_results();

      run_bursts(45, 31);
      drain_results();
      run_bursts(45, 70);
      drain_results();
      run_bursts(25, 0);
      fill_table(0);

      drain_results();
      repeat (300) @(posedge clock);

      if (n_errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
